### rtl/dtdc_pkg.sv
// Shared types, constants and small helper functions for the date text to
// day count block. No dependencies.
`timescale 1ns / 1ps

package dtdc_pkg;

	localparam int MAX_NUMBER_DEF = 9999;

	localparam int CHAR_W        = 8;
	localparam int CFG_YEAR_W    = 14;
	localparam int CFG_DAY_W     = 5;
	localparam int CFG_DATA_W    = 14;
	localparam int CFG_INDEX_W   = 1;
	localparam int DAY_COUNT_W   = 23;
	localparam int WEEKDAY_W     = 3;
	localparam int MONTH_VALUE_W = 14;
	localparam int IN_DATA_W     = 8;
	localparam int OUT_DATA_W    = 40;
	localparam int MONTH_ADD_W   = 9;

	localparam logic [CFG_INDEX_W-1:0] REG_START_YEAR = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_START_DAY  = 1'b1;

	localparam logic [CFG_YEAR_W-1:0] START_YEAR_RST = 14'd2000;
	localparam logic [CFG_DAY_W-1:0]  START_DAY_RST  = 5'd1;

	localparam int MONTH_CLAMP = 13;

	typedef struct packed {
		logic [CFG_YEAR_W-1:0] start_year;
		logic [CFG_DAY_W-1:0]  start_day;
	} cfg_t;

	// Days in the year before the first of month idx+1 (non-leap year);
	// idx 12 stands for a month past December.
	function automatic logic [MONTH_ADD_W-1:0] days_before_month(input logic [3:0] idx);
		logic [MONTH_ADD_W-1:0] d;
		case (idx)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			4'd11:   d = 9'd334;
			4'd12:   d = 9'd365;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	// Remainder by 7 of a byte: octal digits fold since 8 is 1 mod 7.
	function automatic logic [2:0] mod7_small(input logic [7:0] v);
		logic [4:0] a;
		logic [3:0] b;
		a = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[7:6]);
		b = 4'(a[2:0]) + 4'(a[4:3]);
		return (b >= 4'd7) ? 3'(b - 4'd7) : b[2:0];
	endfunction

endpackage

### rtl/dtdc_parse.sv
// Character parser: builds the saturating number and tracks year and month
// fields across a date string. Depends on dtdc_pkg.
`timescale 1ns / 1ps

module dtdc_parse #(
	parameter int MAX_NUMBER = dtdc_pkg::MAX_NUMBER_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  logic [dtdc_pkg::CHAR_W-1:0]         char_code,
	input  logic                                last_char,
	output logic [$clog2(MAX_NUMBER+1)-1:0]     snap_year,
	output logic [$clog2(MAX_NUMBER+1)-1:0]     snap_month,
	output logic [$clog2(MAX_NUMBER+1)-1:0]     snap_day
);
	import dtdc_pkg::*;

	localparam int NUM_W = $clog2(MAX_NUMBER + 1);
	localparam int EXT_W = NUM_W + 4;

	localparam logic [1:0] POS_YEAR  = 2'd0;
	localparam logic [1:0] POS_MONTH = 2'd1;
	localparam logic [1:0] POS_DONE  = 2'd2;

	logic [NUM_W-1:0] acc_q, acc_d;
	logic [1:0]       pos_q, pos_d;
	logic [NUM_W-1:0] year_q, year_d;
	logic [NUM_W-1:0] month_q, month_d;
	logic [NUM_W-1:0] day;
	logic [EXT_W-1:0] ext, prod;
	logic             digit;

	always_comb begin
		acc_d   = acc_q;
		pos_d   = pos_q;
		year_d  = year_q;
		month_d = month_q;
		digit   = char_code inside {[8'h30:8'h39]};
		ext     = EXT_W'(acc_q);
		prod    = (ext << 3) + (ext << 1) + EXT_W'(char_code[3:0]);
		if (digit) begin
			acc_d = (prod > EXT_W'(MAX_NUMBER)) ? NUM_W'(MAX_NUMBER) : NUM_W'(prod);
		end else begin
			case (pos_q)
				POS_YEAR: begin
					year_d = acc_q;
					pos_d  = POS_MONTH;
				end
				POS_MONTH: begin
					month_d = acc_q;
					pos_d   = POS_DONE;
				end
				default: ;
			endcase
			acc_d = '0;
		end
		// the number still open at the final character is the day
		day = acc_d;
		if (last_char) begin
			acc_d = '0;
			pos_d = POS_YEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			pos_q   <= POS_YEAR;
			year_q  <= '0;
			month_q <= '0;
		end else if (accept) begin
			acc_q   <= acc_d;
			pos_q   <= pos_d;
			year_q  <= year_d;
			month_q <= month_d;
		end
	end

	assign snap_year  = year_d;
	assign snap_month = month_d;
	assign snap_day   = day;

	a_acc_sat: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q <= NUM_W'(MAX_NUMBER))
		else $error("digit accumulator above saturation limit");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_char) |=> (acc_q == '0 && pos_q == POS_YEAR))
		else $error("parser not cleared after final character");

endmodule

### rtl/dtdc_count.sv
// Day count pipeline: leap counts by reciprocal division, month table,
// final sum and weekday code, with a per-stage valid/ready chain.
// Depends on dtdc_pkg.
`timescale 1ns / 1ps

module dtdc_count #(
	parameter int MAX_NUMBER = dtdc_pkg::MAX_NUMBER_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  dtdc_pkg::cfg_t                          cfg,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [$clog2(MAX_NUMBER+1)-1:0]         in_year,
	input  logic [$clog2(MAX_NUMBER+1)-1:0]         in_month,
	input  logic [$clog2(MAX_NUMBER+1)-1:0]         in_day,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [dtdc_pkg::DAY_COUNT_W-1:0] day_count,
	output logic [dtdc_pkg::WEEKDAY_W-1:0]          weekday,
	output logic [dtdc_pkg::MONTH_VALUE_W-1:0]      month_value,
	output logic                                    bad_month
);
	import dtdc_pkg::*;

	localparam int NUM_W = $clog2(MAX_NUMBER + 1);
	localparam int YW    = (NUM_W > CFG_YEAR_W) ? NUM_W : CFG_YEAR_W;
	localparam int XW    = YW;
	localparam int PW    = 2 * XW;
	localparam logic [PW-1:0] K25 = PW'((64'd1 << XW) / 25);
	localparam int CNT_W = YW + 11;
	localparam int ND    = (CNT_W + 2) / 3;
	localparam int SW    = $clog2(ND * 7 + 1);

	// divider slots
	localparam int NDIV    = 5;
	localparam int D_C100Y = 0;
	localparam int D_C400Y = 1;
	localparam int D_C100S = 2;
	localparam int D_C400S = 3;
	localparam int D_F100Y = 4;

	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;

	// stage 1: captured date
	logic [NUM_W-1:0] year_s1, month_s1, day_s1;
	// stage 2: quotient estimates
	logic [XW-1:0]    x_s2 [NDIV];
	logic [XW-1:0]    e_s2 [NDIV];
	logic [YW-1:0]    c4y_s2, c4s_s2, ya_s2;
	logic [NUM_W-1:0] month_s2, day_s2;
	// stage 3: corrected quotients and leap flag
	logic [XW-1:0]    q_s3 [NDIV-1];
	logic [YW-1:0]    c4y_s3, c4s_s3, ya_s3;
	logic             leap_s3;
	logic [NUM_W-1:0] month_s3, day_s3;
	// stage 4: partial sums
	logic [CNT_W-1:0]       yd_s4;
	logic [MONTH_ADD_W-1:0] madd_s4;
	logic [NUM_W-1:0]       month_s4, day_s4;
	// stage 5: signed count
	logic signed [CNT_W-1:0] cnt_s5;
	logic [NUM_W-1:0]        month_s5;
	// stage 6: digit sum of magnitude
	logic signed [CNT_W-1:0] cnt_s6;
	logic                    neg_s6;
	logic [SW-1:0]           dsum_s6;
	logic [NUM_W-1:0]        month_s6;
	// stage 7: result
	logic signed [DAY_COUNT_W-1:0] cnt_s7;
	logic [WEEKDAY_W-1:0]          wd_s7;
	logic [MONTH_VALUE_W-1:0]      month_s7;
	logic                          bad_s7;

	// handshake chain: a stage moves when it is empty or its successor moves
	assign adv7     = !valid_s7 || out_ready;
	assign adv6     = !valid_s6 || adv7;
	assign adv5     = !valid_s5 || adv6;
	assign adv4     = !valid_s4 || adv5;
	assign adv3     = !valid_s3 || adv4;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
			if (adv5) valid_s5 <= valid_s4;
			if (adv6) valid_s6 <= valid_s5;
			if (adv7) valid_s7 <= valid_s6;
		end
	end

	// ---- stage 1
	always_ff @(posedge clk) begin
		if (adv1) begin
			year_s1  <= in_year;
			month_s1 <= in_month;
			day_s1   <= in_day;
		end
	end

	// ---- stage 2: x/25 estimated by reciprocal, at most one short
	logic [YW-1:0] ya, sa;
	logic [YW:0]   ya99, ya399, sa99, sa399, ya3, sa3;
	logic [XW-1:0] x [NDIV];
	logic [XW-1:0] e [NDIV];
	logic [PW-1:0] prod [NDIV];

	always_comb begin
		ya    = YW'(year_s1);
		sa    = YW'(cfg.start_year);
		ya99  = (YW+1)'(ya) + (YW+1)'(99);
		ya399 = (YW+1)'(ya) + (YW+1)'(399);
		sa99  = (YW+1)'(sa) + (YW+1)'(99);
		sa399 = (YW+1)'(sa) + (YW+1)'(399);
		ya3   = (YW+1)'(ya) + (YW+1)'(3);
		sa3   = (YW+1)'(sa) + (YW+1)'(3);
		x[D_C100Y] = XW'(ya99 >> 2);
		x[D_C400Y] = XW'(ya399 >> 4);
		x[D_C100S] = XW'(sa99 >> 2);
		x[D_C400S] = XW'(sa399 >> 4);
		x[D_F100Y] = XW'(ya >> 2);
		for (int i = 0; i < NDIV; i++) begin
			prod[i] = PW'(x[i]) * K25;
			e[i]    = prod[i][PW-1:XW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			for (int i = 0; i < NDIV; i++) begin
				x_s2[i] <= x[i];
				e_s2[i] <= e[i];
			end
			c4y_s2   <= YW'(ya3 >> 2);
			c4s_s2   <= YW'(sa3 >> 2);
			ya_s2    <= ya;
			month_s2 <= month_s1;
			day_s2   <= day_s1;
		end
	end

	// ---- stage 3: correct the estimates, derive the leap flag
	logic [XW-1:0] rm [NDIV];
	logic [XW-1:0] q [NDIV];
	logic          div25, leap, rm_ok;

	always_comb begin
		rm_ok = 1'b1;
		for (int i = 0; i < NDIV; i++) begin
			rm[i] = x_s2[i] - XW'(e_s2[i] * XW'(25));
			q[i]  = (rm[i] >= XW'(25)) ? e_s2[i] + XW'(1) : e_s2[i];
			if (rm[i] >= XW'(50)) rm_ok = 1'b0;
		end
		div25 = (rm[D_F100Y] == '0) || (rm[D_F100Y] == XW'(25));
		// divisible by 4, and not a century unless divisible by 400
		leap  = (ya_s2[1:0] == 2'b00) && (!div25 || q[D_F100Y][1:0] == 2'b00);
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			for (int i = 0; i < NDIV - 1; i++) q_s3[i] <= q[i];
			c4y_s3   <= c4y_s2;
			c4s_s3   <= c4s_s2;
			ya_s3    <= ya_s2;
			leap_s3  <= leap;
			month_s3 <= month_s2;
			day_s3   <= day_s2;
		end
	end

	// ---- stage 4: whole years and months
	logic [YW-1:0]          leaps_y, leaps_s, sa4;
	logic [CNT_W-1:0]       yd;
	logic [3:0]             mc;
	logic [MONTH_ADD_W-1:0] madd;

	always_comb begin
		sa4     = YW'(cfg.start_year);
		leaps_y = c4y_s3 - YW'(q_s3[D_C100Y]) + YW'(q_s3[D_C400Y]);
		leaps_s = c4s_s3 - YW'(q_s3[D_C100S]) + YW'(q_s3[D_C400S]);
		if (ya_s3 > sa4) begin
			yd = CNT_W'(ya_s3 - sa4) * CNT_W'(365) + CNT_W'(leaps_y - leaps_s);
		end else begin
			yd = '0;
		end
		mc = (month_s3 > NUM_W'(MONTH_CLAMP)) ? 4'(MONTH_CLAMP) : 4'(month_s3);
		if (mc == 4'd0) begin
			madd = '0;
		end else begin
			madd = days_before_month(mc - 4'd1)
				+ MONTH_ADD_W'((mc > 4'd2) && leap_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			yd_s4    <= yd;
			madd_s4  <= madd;
			month_s4 <= month_s3;
			day_s4   <= day_s3;
		end
	end

	// ---- stage 5: final count
	always_ff @(posedge clk) begin
		if (adv5) begin
			cnt_s5   <= $signed(yd_s4 + CNT_W'(madd_s4) + CNT_W'(day_s4)
				- CNT_W'(cfg.start_day));
			month_s5 <= month_s4;
		end
	end

	// ---- stage 6: octal digit sum of the magnitude
	logic [CNT_W-1:0] mag;
	logic [ND*3-1:0]  mag_pad;
	logic [SW-1:0]    dsum;

	always_comb begin
		mag     = cnt_s5[CNT_W-1] ? CNT_W'(-cnt_s5) : CNT_W'(cnt_s5);
		mag_pad = (ND*3)'(mag);
		dsum    = '0;
		for (int i = 0; i < ND; i++) dsum = dsum + SW'(mag_pad[3*i +: 3]);
	end

	always_ff @(posedge clk) begin
		if (adv6) begin
			cnt_s6   <= cnt_s5;
			neg_s6   <= cnt_s5[CNT_W-1];
			dsum_s6  <= dsum;
			month_s6 <= month_s5;
		end
	end

	// ---- stage 7: weekday code and output register
	logic [2:0]           m7;
	logic [WEEKDAY_W-1:0] wd;

	always_comb begin
		m7 = mod7_small(8'(dsum_s6));
		// remainder keeps the sign of the count
		if (neg_s6) begin
			wd = 3'd6 - m7;
		end else if (m7 > 3'd1) begin
			wd = m7 - 3'd1;
		end else begin
			wd = m7 + 3'd6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv7) begin
			cnt_s7   <= DAY_COUNT_W'(cnt_s6);
			wd_s7    <= wd;
			month_s7 <= MONTH_VALUE_W'(month_s6);
			bad_s7   <= month_s6 > NUM_W'(MONTH_CLAMP);
		end
	end

	assign out_valid   = valid_s7;
	assign day_count   = cnt_s7;
	assign weekday     = wd_s7;
	assign month_value = month_s7;
	assign bad_month   = bad_s7;

	a_recip_close: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> rm_ok)
		else $error("reciprocal quotient estimate off by more than one");

	a_neg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s5 && cnt_s5[CNT_W-1]) |-> (cnt_s5 >= -CNT_W'(31)))
		else $error("negative day count below one month");

endmodule

### rtl/date_text_to_day_count.sv
// Date text to day count: top level with stream ports and config registers.
// Depends on dtdc_pkg, dtdc_parse and dtdc_count.
//
// Usage:
//  - Input stream: one ASCII character per beat in s_axis_tdata; s_axis_tlast
//    marks the final character of a date string such as "2024-03-15".
//  - Output stream: one beat per string, issued for the tlast character.
//  - Config: cfg_wr_en/cfg_index/cfg_data write start_year (index 0) and
//    start_day (index 1); write only while no string is in flight.
//  - Throughput: one character per cycle while s_axis_tready is high, strings back to back.
//  - The result beat is registered through the seven-stage count pipeline
//    (divide, correct, sum, weekday) once the tlast beat is taken.
//  - Reset clears the parser, the pipeline valids and loads start_year 2000,
//    start_day 1.
//  - A stalled receiver holds the result beat; characters keep flowing while
//    empty pipeline stages remain, then s_axis_tready drops.
`timescale 1ns / 1ps

module date_text_to_day_count #(
	parameter int MAX_NUMBER = dtdc_pkg::MAX_NUMBER_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// config write port
	input  logic                                 cfg_wr_en,
	input  logic [dtdc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [dtdc_pkg::CFG_DATA_W-1:0]      cfg_data,
	// character stream
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [dtdc_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // [7:0] char_code
	input  logic                                 s_axis_tlast,  // last_char
	// result stream
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [22:0] day_count, [25:23] weekday, [39:26] month_value
	output logic [dtdc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	output logic                                 m_axis_tuser   // bad_month
);
	import dtdc_pkg::*;

	localparam int NUM_W = $clog2(MAX_NUMBER + 1);

	cfg_t cfg_q;

	logic                          accept;
	logic [NUM_W-1:0]              snap_year, snap_month, snap_day;
	logic signed [DAY_COUNT_W-1:0] day_count;
	logic [WEEKDAY_W-1:0]          weekday;
	logic [MONTH_VALUE_W-1:0]      month_value;
	logic                          bad_month;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_year <= START_YEAR_RST;
			cfg_q.start_day  <= START_DAY_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_START_YEAR: cfg_q.start_year <= CFG_YEAR_W'(cfg_data);
				REG_START_DAY:  cfg_q.start_day  <= CFG_DAY_W'(cfg_data);
				default: ;
			endcase
		end
	end

	assign accept = s_axis_tvalid && s_axis_tready;

	dtdc_parse #(
		.MAX_NUMBER (MAX_NUMBER)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.char_code  (s_axis_tdata),
		.last_char  (s_axis_tlast),
		.snap_year  (snap_year),
		.snap_month (snap_month),
		.snap_day   (snap_day)
	);

	dtdc_count #(
		.MAX_NUMBER (MAX_NUMBER)
	) u_count (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (accept && s_axis_tlast),
		.in_ready    (s_axis_tready),
		.in_year     (snap_year),
		.in_month    (snap_month),
		.in_day      (snap_day),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.day_count   (day_count),
		.weekday     (weekday),
		.month_value (month_value),
		.bad_month   (bad_month)
	);

	assign m_axis_tdata = {month_value, weekday, day_count};
	assign m_axis_tuser = bad_month;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for date_text_to_day_count: streams date strings one character per beat
// and checks each result beat against a bench day-count predictor or typed expected results.
// Depends on dtdc_pkg and the date_text_to_day_count RTL.

module tb;
	import dtdc_pkg::*;

	typedef struct packed {
		logic [DAY_COUNT_W-1:0]   day_count;
		logic [WEEKDAY_W-1:0]     weekday;
		logic [MONTH_VALUE_W-1:0] month_value;
		logic                     bad_month;
	} date_result_t;

	typedef struct {
		string        text;
		bit           typed;
		date_result_t want;
	} date_case_t;

	localparam logic [7:0] CH_0    = "0";
	localparam logic [7:0] CH_9    = "9";
	localparam logic [7:0] CH_DASH = "-";
	localparam int DRAIN_CYCLES    = 12;
	localparam int PHASE_CHARS     = 260;
	localparam int NUM_PHASES      = 6;

	// days before the first of each month, non-leap; entry 12 is a full year
	localparam int DAYS_BEFORE [13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334,
		365};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_START_YEAR;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata = '0;   // [7:0] char_code
	logic                   s_axis_tlast = 1'b0; // last_char
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// [22:0] day_count, [25:23] weekday, [39:26] month_value
	logic [OUT_DATA_W-1:0]  m_axis_tdata;
	logic                   m_axis_tuser;        // bad_month

	// predictor copy of configuration and parser state
	int org_year = START_YEAR_RST;
	int org_day  = START_DAY_RST;
	int acc_num, field_idx, held_year, held_month;

	date_result_t pending_dates[$];
	date_result_t typed_want;
	bit           use_typed;
	int           chars_sent;
	int           mismatches;
	bit           rx_calm;

	date_case_t directed_cases[7] = '{
		'{"2000-1-1",  1'b1, '{23'd0,       3'd6, 14'd1,  1'b0}},
		'{"0.0.0",     1'b1, '{23'h7FFFFF,  3'd5, 14'd0,  1'b0}},
		'{"9-14-1",    1'b1, '{23'd365,     3'd7, 14'd14, 1'b1}},
		'{"99999/13/", 1'b0, '0},
		'{"7",         1'b0, '0},
		'{"x",         1'b0, '0},
		'{"1:2:3:4",   1'b0, '0}
	};

	date_text_to_day_count u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit leap_year(input int y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	// leap years among years 0 .. n-1
	function automatic int leaps_under(input int n);
		return (n + 3) / 4 - (n + 99) / 100 + (n + 399) / 400;
	endfunction

	function automatic date_result_t day_count_of(input int day);
		date_result_t res;
		int cnt, m, add, r;
		cnt = 0;
		if (held_year > org_year)
			cnt = (held_year - org_year) * 365 + leaps_under(held_year) - leaps_under(org_year);
		m = (held_month > MONTH_CLAMP) ? MONTH_CLAMP : held_month;
		if (m >= 1) begin
			add = DAYS_BEFORE[m - 1];
			if (m > 2 && leap_year(held_year))
				add++;
			cnt += add;
		end
		cnt += day - org_day;
		// remainder truncates toward zero, so negative counts give negative r
		r = cnt % 7;
		res.day_count   = cnt[DAY_COUNT_W-1:0];
		res.weekday     = WEEKDAY_W'((r > 1) ? r - 1 : r + 6);
		res.month_value = held_month[MONTH_VALUE_W-1:0];
		res.bad_month   = held_month > MONTH_CLAMP;
		return res;
	endfunction

	// advance the parser by one character; returns 1 when a date closes
	function automatic bit step_date(input logic [7:0] c, input bit last,
		output date_result_t res);
		int v;
		res = '0;
		if (c >= CH_0 && c <= CH_9) begin
			v = acc_num * 10 + int'(c - CH_0);
			acc_num = (v > MAX_NUMBER_DEF) ? MAX_NUMBER_DEF : v;
		end else begin
			if (field_idx == 0)
				held_year = acc_num;
			else if (field_idx == 1)
				held_month = acc_num;
			if (field_idx < 2)
				field_idx++;
			acc_num = 0;
		end
		if (!last)
			return 1'b0;
		res = day_count_of(acc_num);
		acc_num = 0;
		field_idx = 0;
		return 1'b1;
	endfunction

	task automatic send_char(input logic [7:0] c, input bit last, input bit no_gaps);
		int gap;
		date_result_t res;
		gap = no_gaps ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		chars_sent++;
		if (step_date(c, last, res)) begin
			if (use_typed)
				pending_dates.push_back(typed_want);
			else
				pending_dates.push_back(res);
			use_typed = 1'b0;
		end
	endtask

	task automatic send_bytes(ref logic [7:0] q[$], input bit no_gaps);
		for (int i = 0; i < q.size(); i++)
			send_char(q[i], i == q.size() - 1, no_gaps);
	endtask

	function automatic void push_text(ref logic [7:0] q[$], input string s);
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
	endfunction

	// negative value leaves the field empty
	function automatic void push_number(ref logic [7:0] q[$], input int v);
		if (v < 0)
			return;
		if ($urandom_range(0, 7) == 0)
			q.push_back(CH_0);
		push_text(q, $sformatf("%0d", v));
	endfunction

	function automatic logic [7:0] any_separator();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c >= CH_0 && c <= CH_9);
		return c;
	endfunction

	function automatic int pick_year();
		int y;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				y = org_year + int'($urandom_range(0, 80)) - 40;
				return (y < 0) ? 0 : y;
			end
			5, 6:    return $urandom_range(0, 9999);
			7:       return $urandom_range(10000, 999999);
			8:       return org_year;
			default: return -1;
		endcase
	endfunction

	function automatic int pick_month();
		case ($urandom_range(0, 9))
			7:       return $urandom_range(0, 15);
			8:       return $urandom_range(16, 99999);
			9:       return -1;
			default: return $urandom_range(1, 12);
		endcase
	endfunction

	function automatic int pick_day();
		case ($urandom_range(0, 9))
			7:       return 0;
			8:       return $urandom_range(32, 99999);
			9:       return -1;
			default: return $urandom_range(1, 31);
		endcase
	endfunction

	task automatic send_random_date();
		logic [7:0] q[$];
		logic [7:0] sep;
		int kind;
		bit no_gaps;
		no_gaps = ($urandom_range(0, 3) == 0);
		kind = $urandom_range(0, 15);
		if (kind < 12) begin
			sep = $urandom_range(0, 1) ? CH_DASH : any_separator();
			// kind 11 carries only a day, kind 10 drops the month
			if (kind != 11) begin
				push_number(q, pick_year());
				q.push_back(sep);
			end
			if (kind < 10) begin
				push_number(q, pick_month());
				q.push_back($urandom_range(0, 1) ? sep : any_separator());
			end
			push_number(q, pick_day());
			if (kind == 9)
				q.push_back(sep);
			if (kind == 8) begin
				q.push_back(sep);
				push_number(q, $urandom_range(0, 99999));
			end
			if (q.size() == 0)
				q.push_back(sep);
		end else begin
			repeat ($urandom_range(1, 12))
				q.push_back($urandom_range(0, 1) ? 8'($urandom_range(CH_0, CH_9))
					: 8'($urandom_range(0, 255)));
		end
		send_bytes(q, no_gaps);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		@(posedge clk);
		if (idx == REG_START_YEAR)
			org_year = val & ((1 << CFG_YEAR_W) - 1);
		else
			org_day = val & ((1 << CFG_DAY_W) - 1);
	endtask

	task automatic wait_idle();
		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// result sink: stall a random number of cycles per beat, with calm stretches
	initial begin
		int stall;
		forever begin
			if ($urandom_range(0, 15) == 0)
				rx_calm = !rx_calm;
			stall = rx_calm ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		date_result_t want, got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.day_count   = m_axis_tdata[DAY_COUNT_W-1:0];
			got.weekday     = m_axis_tdata[DAY_COUNT_W +: WEEKDAY_W];
			got.month_value = m_axis_tdata[DAY_COUNT_W+WEEKDAY_W +: MONTH_VALUE_W];
			got.bad_month   = m_axis_tuser;
			if (pending_dates.size() == 0) begin
				$display("%0t: unexpected beat, expected none actual %h", $time, got);
				mismatches++;
			end else begin
				want = pending_dates.pop_front();
				check_field("day_count", int'($signed(want.day_count)),
					int'($signed(got.day_count)));
				check_field("weekday", want.weekday, got.weekday);
				check_field("month_value", want.month_value, got.month_value);
				check_field("bad_month", want.bad_month, got.bad_month);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		logic [7:0] q[$];
		int target;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed strings run on the reset configuration
		foreach (directed_cases[i]) begin
			q.delete();
			push_text(q, directed_cases[i].text);
			use_typed  = directed_cases[i].typed;
			typed_want = directed_cases[i].want;
			send_bytes(q, i[0]);
		end
		s_axis_tvalid <= 1'b0;

		target = chars_sent;
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			case (p)
				0: begin
					write_reg(REG_START_YEAR, 0);
					write_reg(REG_START_DAY, 31);
				end
				1: begin
					write_reg(REG_START_YEAR, 9999);
					write_reg(REG_START_DAY, 1);
				end
				2: begin
					write_reg(REG_START_DAY, 31);
				end
				3: begin
					write_reg(REG_START_YEAR, 0);
					write_reg(REG_START_DAY, 1);
				end
				default: begin
					write_reg(REG_START_YEAR, $urandom_range(0, 9999));
					write_reg(REG_START_DAY, $urandom_range(1, 31));
				end
			endcase
			cfg_wr_en <= 1'b0;
			target += PHASE_CHARS;
			while (chars_sent < target)
				send_random_date();
			s_axis_tvalid <= 1'b0;
		end

		wait_idle();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
